/* hw/rtl/ir_key_repeat_filter_fifo_top_defines.svh */
// ----------------------------------------------------------------------------
// ir key repeat filter fifo - assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef IR_KEY_REPEAT_FILTER_FIFO_TOP_DEFINES_SVH
`define IR_KEY_REPEAT_FILTER_FIFO_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define IRKRF_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define IRKRF_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* hw/rtl/irkrf_pkg.sv */
// ----------------------------------------------------------------------------
// irkrf_pkg
// types, codes and constants of the ir key repeat filter fifo
// ----------------------------------------------------------------------------
`default_nettype none

package irkrf_pkg;

  localparam int FIFO_ADDR_BITS = 8;
  localparam int FIFO_DEPTH     = 1 << FIFO_ADDR_BITS;
  localparam int KEY_W          = 32;

  localparam logic [15:0] RC5_BASE         = 16'h3000;
  localparam int          RC5_TOGGLE_SHIFT = 11;
  localparam int          RC5_GROUP_SHIFT  = 6;
  localparam int          RC6_HEADER_SHIFT = 16;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_POP   = 1'b1;

  localparam logic [2:0] PROTO_NEC32 = 3'd0;
  localparam logic [2:0] PROTO_NEC40 = 3'd1;
  localparam logic [2:0] PROTO_RC5   = 3'd2;
  localparam logic [2:0] PROTO_RC6   = 3'd3;

  typedef logic [FIFO_ADDR_BITS-1:0] ptr_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic        op;
    logic [2:0]  protocol;
    logic [7:0]  addr_byte;
    logic [7:0]  data_byte;
    logic        is_repeat;
    logic        toggle_bit;
    logic [4:0]  group_field;
    logic [5:0]  command_field;
    logic [15:0] header_field;
    logic [15:0] info_field;
  } in_word_t;

  typedef struct packed {
    logic [31:0] key_out;
    logic        key_valid;
    logic        stored;
    logic        suppressed;
    logic        overflow;
    logic [7:0]  fill_level;
  } out_word_t;

endpackage

`default_nettype wire

/* hw/rtl/irkrf_ram.sv */
// ----------------------------------------------------------------------------
// irkrf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module irkrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ir_key_repeat_filter_fifo_top.sv */
// ----------------------------------------------------------------------------
// ir_key_repeat_filter_fifo_top
// packs decoded ir frames into key codes, filters nec repeats and queues
// keys in a ram based ring fifo that pop requests drain
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  in_     | in  | in_valid/in_ready   | in_word_t: op, frame fields
//  out_    | out | out_valid/out_ready | out_word_t: key, flags, fill level
//  cfg_    | in  | cfg_valid/cfg_ready | min_repeat, 16 bit
//
// a frame item's result is registered into the output register in the cycle
// after the item is taken. a pop of a non-empty fifo passes through the key
// ram's registered read and st_read before its key is in the output register.
// reset clears pointers, repeat filter and min_repeat; the key ram is not
// cleared. the input stalls while the output register holds an untaken
// result and while a pop's key read is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_key_repeat_filter_fifo_top_defines.svh"

module ir_key_repeat_filter_fifo_top
  import irkrf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [15:0] cfg_data
);

  state_t      state_r, state_nxt;
  ptr_t        rd_ptr_r, rd_ptr_nxt;
  ptr_t        wr_ptr_r, wr_ptr_nxt;
  logic [15:0] last_key_r, last_key_nxt;
  logic [15:0] rep_cnt_r, rep_cnt_nxt;
  logic [15:0] min_repeat_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  logic        in_fire;
  logic        fifo_empty;
  logic        fifo_full;
  logic        pop_read;
  logic        ram_we;
  logic [31:0] key;
  logic [31:0] ram_rdata;
  ptr_t        fill_now;

  assign in_fire    = in_valid && in_ready;
  assign fifo_empty = (rd_ptr_r == wr_ptr_r);
  assign fifo_full  = (ptr_t'(wr_ptr_r + 1'b1) == rd_ptr_r);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign fill_now   = ptr_t'(wr_ptr_r - rd_ptr_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.op == OP_POP && !fifo_empty) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    pop_read = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        pop_read = in_valid && in_ready && in_data.op == OP_POP && !fifo_empty;
      end
      ST_READ: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // frame packing, repeat filter and pointer updates
  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    last_key_nxt  = last_key_r;
    rep_cnt_nxt   = rep_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    key           = '0;

    if (state_r == ST_READ) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt            = '0;
      out_data_nxt.key_out    = ram_rdata;
      out_data_nxt.key_valid  = 1'b1;
      out_data_nxt.fill_level = 8'(fill_now);
    end else if (in_fire) begin
      out_data_nxt = '0;
      if (in_data.op == OP_POP) begin
        if (!fifo_empty) begin
          rd_ptr_nxt = ptr_t'(rd_ptr_r + 1'b1);
        end else begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.fill_level = 8'(fill_now);
        end
      end else begin
        out_valid_nxt = 1'b1;
        case (in_data.protocol) inside
          PROTO_NEC32, PROTO_NEC40: begin
            key = {16'h0, in_data.addr_byte, in_data.data_byte};
            if (in_data.is_repeat && key[15:0] == last_key_r && rep_cnt_r < min_repeat_r) begin
              rep_cnt_nxt             = rep_cnt_r + 16'd1;
              out_data_nxt.suppressed = 1'b1;
            end else begin
              rep_cnt_nxt  = '0;
              last_key_nxt = key[15:0];
              ram_we       = 1'b1;
            end
          end
          PROTO_RC5: begin
            key = {16'h0, RC5_BASE
                   | (16'(in_data.toggle_bit) << RC5_TOGGLE_SHIFT)
                   | (16'(in_data.group_field) << RC5_GROUP_SHIFT)
                   | 16'(in_data.command_field)};
            ram_we = 1'b1;
          end
          PROTO_RC6: begin
            key    = (32'(in_data.header_field) << RC6_HEADER_SHIFT)
                     | 32'(in_data.info_field);
            ram_we = 1'b1;
          end
          default: begin
            key = '0;
          end
        endcase
        // full fifo drops the key
        if (ram_we && fifo_full) begin
          ram_we                = 1'b0;
          out_data_nxt.overflow = 1'b1;
        end
        if (ram_we) begin
          wr_ptr_nxt          = ptr_t'(wr_ptr_r + 1'b1);
          out_data_nxt.stored = 1'b1;
        end
        out_data_nxt.fill_level = 8'(ptr_t'(wr_ptr_nxt - rd_ptr_r));
      end
    end
  end

  irkrf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (key),
    .re    (pop_read),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      last_key_r   <= '0;
      rep_cnt_r    <= '0;
      min_repeat_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      last_key_r  <= last_key_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        min_repeat_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `IRKRF_ASSERT_NEXT(a_frame_result, in_fire && in_data.op == OP_FRAME,
    out_valid_r && !out_data_r.key_valid && out_data_r.key_out == '0,
    "frame word did not give a keyless result on the next cycle")
  `IRKRF_ASSERT_NOW(a_read_slot_free, state_r == ST_READ, !out_valid_r,
    "output register busy while a key read is in flight")
  `IRKRF_ASSERT_NEXT(a_empty_pop, in_fire && in_data.op == OP_POP && fifo_empty,
    out_valid_r && !out_data_r.key_valid && rd_ptr_r == $past(rd_ptr_r),
    "pop of an empty fifo changed state or returned a key")
  `IRKRF_ASSERT_NOW(a_store_not_full, ram_we, !fifo_full,
    "key written into a full fifo")

endmodule

`default_nettype wire
